>>> design/fsa_pkg.sv
// Shared types, codes and constants for the fragmented sparse array.
// Used by fsa_ctrl, fsa_datapath and the fragmented_sparse_array top level.
// No dependencies.
package fsa_pkg;

  // Default sizes handed down from the top level.
  localparam int DEF_MAX_FRAGMENTS       = 16;
  localparam int DEF_MAX_FRAGMENT_LENGTH = 64;
  localparam int DEF_KEY_WIDTH           = 32;

  // Fixed field widths.
  localparam int IDX_W        = 16;
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int USED_W       = 11;
  localparam int ACTIVE_W     = 5;
  localparam int ALLOC_W      = 11;
  localparam int OUT_USER_W   = 5;
  localparam int CFG_COUNT_W  = 5;
  localparam int CFG_LENGTH_W = 7;
  localparam int CFG_DATA_W   = 7;
  localparam int CFG_INDEX_W  = 1;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_SET   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_DEL   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_DEL_EMPTY = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAG_COUNT  = 1'b0,
    CFG_FRAG_LENGTH = 1'b1
  } cfg_index_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_READ,
    S_MODIFY,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clear_counts;
    logic sweep_run;
    logic div_start;
    logic div_step;
    logic mark_invalid;
    logic modify;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cfg_fire;
    logic in_clear;
    logic req_clear;
    logic idx_invalid;
    logic div_last;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/fsa_ctrl.sv
// Controller state machine for the fragmented sparse array.
// Depends on fsa_pkg; drives dp_cmd_t commands into fsa_datapath.
module fsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fsa_pkg::dp_stat_t  stat,
  output fsa_pkg::dp_cmd_t   cmd
);
  import fsa_pkg::*;

  state_t state;
  state_t state_next;

  // State register; reset starts with a memory clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state logic. A configuration write restarts the sweep.
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = stat.in_clear ? S_RESULT : S_CHECK;
      end
      S_CHECK: begin
        state_next = stat.idx_invalid ? S_RESULT : S_DIV;
      end
      S_DIV: begin
        if (stat.div_last) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_next = stat.req_clear ? S_SWEEP : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (stat.cfg_fire) state_next = S_SWEEP;
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep_run = 1'b1;
      end
      S_IDLE: begin
        in_ready         = 1'b1;
        cmd.load_in      = in_valid;
        cmd.clear_counts = in_valid & stat.in_clear;
      end
      S_CHECK: begin
        cmd.div_start    = ~stat.idx_invalid;
        cmd.mark_invalid = stat.idx_invalid;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_READ: begin
        cmd = '0;
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
      end
      S_RESULT: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> design/fsa_datapath.sv
// Datapath of the fragmented sparse array: configuration, radix-4 divider,
// cell memory, fragment fill counters and the output register.
// Depends on fsa_pkg; commanded by fsa_ctrl.
module fsa_datapath #(
  parameter int MAX_FRAGMENTS       = fsa_pkg::DEF_MAX_FRAGMENTS,
  parameter int MAX_FRAGMENT_LENGTH = fsa_pkg::DEF_MAX_FRAGMENT_LENGTH,
  parameter int KEY_WIDTH           = fsa_pkg::DEF_KEY_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input transaction payload.
  input  logic [((fsa_pkg::IDX_W + KEY_WIDTH + 7) / 8) * 8 - 1:0] in_data,
  input  logic [fsa_pkg::REQ_W-1:0]           in_user,
  // Configuration write.
  input  logic                                cfg_fire,
  input  logic [fsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fsa_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Controller interface.
  input  fsa_pkg::dp_cmd_t                    cmd,
  output fsa_pkg::dp_stat_t                   stat,
  // Output register.
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [((KEY_WIDTH + fsa_pkg::USED_W + fsa_pkg::ACTIVE_W + fsa_pkg::ALLOC_W + 7)
                 / 8) * 8 - 1:0]              out_data,
  output logic [fsa_pkg::OUT_USER_W-1:0]      out_user
);
  import fsa_pkg::*;

  localparam int OUT_DW = ((KEY_WIDTH + USED_W + ACTIVE_W + ALLOC_W + 7) / 8) * 8;
  localparam int FCW    = ($clog2(MAX_FRAGMENTS + 1) > CFG_COUNT_W) ?
                          $clog2(MAX_FRAGMENTS + 1) : CFG_COUNT_W;
  localparam int LW     = ($clog2(MAX_FRAGMENT_LENGTH + 1) > CFG_LENGTH_W) ?
                          $clog2(MAX_FRAGMENT_LENGTH + 1) : CFG_LENGTH_W;
  localparam int CAPW   = FCW + LW;
  localparam int DEPTH  = MAX_FRAGMENTS * MAX_FRAGMENT_LENGTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW     = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int FLW    = $clog2(MAX_FRAGMENT_LENGTH + 1);
  localparam int TW     = $clog2(DEPTH + 1);
  localparam int ACW    = $clog2(MAX_FRAGMENTS + 1);
  localparam int STEPS  = IDX_W / 2;
  localparam int SCW    = $clog2(STEPS);
  localparam int PW     = AW + FW + LW;

  // Configuration and capacity.
  logic [FCW-1:0]  frag_count;
  logic [LW-1:0]   frag_len;
  logic [CAPW-1:0] cap;

  // Latched request; idx_q shifts into the quotient during division.
  req_t                 req_q;
  logic [IDX_W-1:0]     idx_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [LW-1:0]        rem;
  logic [SCW-1:0]       div_cnt;

  // Cell memory: used bit over the key.
  logic [KEY_WIDTH:0]   mem [DEPTH];
  logic [KEY_WIDTH:0]   mem_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [KEY_WIDTH:0]   mem_wd;
  logic [AW-1:0]        sweep_addr;

  // Fragment fill counters and totals.
  logic [FLW-1:0]       fill [MAX_FRAGMENTS];
  logic [TW-1:0]        total;
  logic [ACW-1:0]       active;

  // Result fields of the current request.
  status_t              res_status;
  logic [KEY_WIDTH-1:0] res_value;
  logic                 res_empty;
  logic                 res_spawned;
  logic                 res_freed;

  // Divider step, address and cell decode signals.
  logic [LW:0]          trial_a;
  logic [LW:0]          trial_b;
  logic                 ge_a;
  logic                 ge_b;
  logic [LW-1:0]        rem_a;
  logic [LW-1:0]        rem_b;
  logic [FW-1:0]        frag;
  logic [PW-1:0]        pos_wide;
  logic [AW-1:0]        pos;
  logic                 cell_used;
  logic [FLW-1:0]       fill_cur;
  logic [OUT_DW-1:0]    out_data_next;

  // Two restoring division steps per cycle.
  always_comb begin
    trial_a = {rem, idx_q[IDX_W-1]};
    ge_a    = trial_a >= {1'b0, frag_len};
    rem_a   = ge_a ? LW'(trial_a - {1'b0, frag_len}) : LW'(trial_a);
    trial_b = {rem_a, idx_q[IDX_W-2]};
    ge_b    = trial_b >= {1'b0, frag_len};
    rem_b   = ge_b ? LW'(trial_b - {1'b0, frag_len}) : LW'(trial_b);
  end

  // Cell address from the quotient and remainder.
  assign frag      = idx_q[FW-1:0];
  assign pos_wide  = PW'(frag) * PW'(MAX_FRAGMENT_LENGTH) + PW'(rem);
  assign pos       = pos_wide[AW-1:0];
  assign cell_used = mem_q[KEY_WIDTH];
  assign fill_cur  = fill[frag];

  // Memory write port: clearing sweep or request update.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos;
    mem_wd = '0;
    if (cmd.sweep_run) begin
      mem_we = 1'b1;
      mem_wa = sweep_addr;
    end else if (cmd.modify) begin
      case (req_q)
        REQ_SET: begin
          mem_we = 1'b1;
          mem_wd = {1'b1, key_q};
        end
        REQ_DEL: begin
          mem_we = cell_used;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // Cell memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[pos];
  end

  // Status toward the controller.
  always_comb begin
    stat.cfg_fire    = cfg_fire;
    stat.in_clear    = (in_user == REQ_CLEAR);
    stat.req_clear   = (req_q == REQ_CLEAR);
    stat.idx_invalid = (32'(idx_q) >= 32'(cap));
    stat.div_last    = (div_cnt == SCW'(STEPS - 1));
    stat.sweep_last  = (sweep_addr == AW'(DEPTH - 1));
    stat.out_free    = ~out_valid | out_ready;
  end

  // Configuration registers, saturated to the built sizes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frag_count <= FCW'(MAX_FRAGMENTS);
      frag_len   <= LW'(MAX_FRAGMENT_LENGTH);
    end else if (cfg_fire) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAG_COUNT: begin
          frag_count <= (32'(cfg_data[CFG_COUNT_W-1:0]) > MAX_FRAGMENTS) ?
                        FCW'(MAX_FRAGMENTS) : FCW'(cfg_data[CFG_COUNT_W-1:0]);
        end
        CFG_FRAG_LENGTH: begin
          frag_len <= (32'(cfg_data[CFG_LENGTH_W-1:0]) > MAX_FRAGMENT_LENGTH) ?
                      LW'(MAX_FRAGMENT_LENGTH) : LW'(cfg_data[CFG_LENGTH_W-1:0]);
        end
        default: begin
          frag_len <= frag_len;
        end
      endcase
    end
  end

  // Capacity is registered and follows the configuration in the next cycle.
  always_ff @(posedge clk) begin
    cap <= CAPW'(frag_count) * CAPW'(frag_len);
  end

  // Sweep address; restarts on a configuration write.
  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_run) begin
      sweep_addr <= stat.sweep_last ? '0 : sweep_addr + AW'(1);
    end
  end

  // Request capture and division.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_q <= req_t'(in_user);
      idx_q <= in_data[IDX_W-1:0];
      key_q <= in_data[IDX_W +: KEY_WIDTH];
    end else if (cmd.div_start) begin
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_b;
      idx_q   <= {idx_q[IDX_W-3:0], ge_a, ge_b};
      div_cnt <= div_cnt + SCW'(1);
    end
  end

  // Result fields of the current request.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_status  <= STAT_OK;
      res_value   <= '0;
      res_empty   <= 1'b0;
      res_spawned <= 1'b0;
      res_freed   <= 1'b0;
    end else if (cmd.mark_invalid) begin
      res_status <= STAT_BAD_INDEX;
    end else if (cmd.modify) begin
      case (req_q)
        REQ_SET: begin
          res_spawned <= (fill_cur == '0);
        end
        REQ_GET: begin
          res_value <= cell_used ? mem_q[KEY_WIDTH-1:0] : '0;
          res_empty <= ~cell_used;
        end
        REQ_DEL: begin
          res_status <= cell_used ? STAT_OK : STAT_DEL_EMPTY;
          res_freed  <= cell_used & (fill_cur == FLW'(1));
        end
        default: begin
          res_status <= STAT_OK;
        end
      endcase
    end
  end

  // Fill counters, used cell total and active fragment count.
  always_ff @(posedge clk) begin
    if (rst || cfg_fire || cmd.clear_counts) begin
      fill   <= '{default: '0};
      total  <= '0;
      active <= '0;
    end else if (cmd.modify) begin
      case (req_q)
        REQ_SET: begin
          if (!cell_used) begin
            fill[frag] <= fill_cur + FLW'(1);
            total      <= total + TW'(1);
            if (fill_cur == '0) active <= active + ACW'(1);
          end
        end
        REQ_DEL: begin
          if (cell_used) begin
            fill[frag] <= fill_cur - FLW'(1);
            total      <= total - TW'(1);
            if (fill_cur == FLW'(1)) active <= active - ACW'(1);
          end
        end
        default: begin
          total <= total;
        end
      endcase
    end
  end

  // Packing of the result transaction.
  always_comb begin
    out_data_next = '0;
    out_data_next[KEY_WIDTH-1:0]                          = res_value;
    out_data_next[KEY_WIDTH +: USED_W]                    = USED_W'(total);
    out_data_next[KEY_WIDTH + USED_W +: ACTIVE_W]         = ACTIVE_W'(active);
    out_data_next[KEY_WIDTH + USED_W + ACTIVE_W +: ALLOC_W] =
      ALLOC_W'(frag_len) * ALLOC_W'(active);
  end

  // Output register holds a finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= out_data_next;
      out_user <= {res_freed, res_spawned, res_empty, res_status};
    end
  end

endmodule

>>> design/fragmented_sparse_array.sv
// Top level of the fragmented sparse array.
// Depends on fsa_pkg, fsa_ctrl and fsa_datapath.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser req_type, tdata index and key
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser status and flags, tdata value, counts
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A set, get or delete passes from acceptance to a loaded result through
// one capacity check, 8 radix-4 divider steps for the fragment and offset,
// and a read, a modify and a result state on the cell memory; the next
// item is accepted only after the result is loaded into the output register.
// An index at or above the capacity skips the divider and goes to the result state.
// Reset, a clear request and every register write start a clearing pass over all
// MAX_FRAGMENTS * MAX_FRAGMENT_LENGTH cells (1024 by default) with s_axis_tready low.
// A result waits in the output register while the next item is accepted.
module fragmented_sparse_array #(
  parameter int MAX_FRAGMENTS       = fsa_pkg::DEF_MAX_FRAGMENTS,
  parameter int MAX_FRAGMENT_LENGTH = fsa_pkg::DEF_MAX_FRAGMENT_LENGTH,
  parameter int KEY_WIDTH           = fsa_pkg::DEF_KEY_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // Request stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // cell_index, key_value
  input  logic [((fsa_pkg::IDX_W + KEY_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // req_type
  input  logic [fsa_pkg::REQ_W-1:0]        s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_value, used_cells, active_fragments, allocated_cells
  output logic [((KEY_WIDTH + fsa_pkg::USED_W + fsa_pkg::ACTIVE_W + fsa_pkg::ALLOC_W + 7)
                 / 8) * 8 - 1:0]           m_axis_tdata,
  // status, read_empty, fragment_spawned, fragment_freed
  output logic [fsa_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fsa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_fire;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  fsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsa_datapath #(
    .MAX_FRAGMENTS       (MAX_FRAGMENTS),
    .MAX_FRAGMENT_LENGTH (MAX_FRAGMENT_LENGTH),
    .KEY_WIDTH           (KEY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

>>> bench/fragmented_sparse_array_tb.sv
// Self-checking testbench for the fragmented sparse array top level.
// Depends on fsa_pkg and fragmented_sparse_array; predicts every result in
// the bench itself and compares it with the result stream.
`timescale 1ns / 100ps

module fragmented_sparse_array_tb;
  import fsa_pkg::*;

  localparam int KEY_W      = DEF_KEY_WIDTH;
  localparam int MAX_FRAGS  = DEF_MAX_FRAGMENTS;
  localparam int MAX_LEN    = DEF_MAX_FRAGMENT_LENGTH;
  localparam int CELL_DEPTH = MAX_FRAGS * MAX_LEN;
  localparam int S_DATA_W   = ((IDX_W + KEY_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((KEY_W + USED_W + ACTIVE_W + ALLOC_W + 7) / 8) * 8;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int NUM_PHASES = 11;

  // One request as it travels on the input stream.
  typedef struct {
    req_t             req;
    logic [IDX_W-1:0] index;
    logic [KEY_W-1:0] key;
  } request_t;

  // One result as it travels on the output stream.
  typedef struct packed {
    status_t             status;
    logic [KEY_W-1:0]    read_value;
    logic                read_empty;
    logic                spawned;
    logic                freed;
    logic [USED_W-1:0]   used;
    logic [ACTIVE_W-1:0] active;
    logic [ALLOC_W-1:0]  alloc;
  } result_t;

  // Receiver stall patterns.
  typedef enum int {
    RX_STEADY,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [REQ_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index = CFG_FRAG_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fragmented_sparse_array dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the array state and the two registers.
  logic [KEY_W-1:0] key_mem [CELL_DEPTH];
  bit               used_mem [CELL_DEPTH];
  int               frag_fill [MAX_FRAGS];
  bit               frag_active [MAX_FRAGS];
  int               used_total;
  int               active_total;
  int               frag_count_cfg;
  int               frag_len_cfg;

  request_t pending [$];
  result_t  expected [$];
  int       requests_queued = 0;
  int       requests_sent = 0;
  int       err_count = 0;
  int       holdoff_requests = 0;

  function automatic void empty_array();
    for (int i = 0; i < CELL_DEPTH; i++) begin
      key_mem[i] = '0;
      used_mem[i] = 1'b0;
    end
    for (int f = 0; f < MAX_FRAGS; f++) begin
      frag_fill[f] = 0;
      frag_active[f] = 1'b0;
    end
    used_total = 0;
    active_total = 0;
  endfunction

  // A register write saturates its value and always empties the array.
  function automatic void apply_register_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    int v;
    if (idx == CFG_FRAG_COUNT) begin
      v = int'(data[CFG_COUNT_W-1:0]);
      frag_count_cfg = (v > MAX_FRAGS) ? MAX_FRAGS : v;
    end else begin
      v = int'(data[CFG_LENGTH_W-1:0]);
      frag_len_cfg = (v > MAX_LEN) ? MAX_LEN : v;
    end
    empty_array();
  endfunction

  // Applies one request to the shadow state and returns the result it gives.
  function automatic result_t apply_request(request_t rq);
    result_t r;
    int      capacity;
    int      frag;
    int      offset;
    int      pos;
    r = '0;
    r.status = STAT_OK;
    capacity = frag_count_cfg * frag_len_cfg;
    if (rq.req == REQ_CLEAR) begin
      empty_array();
    end else if (rq.index >= capacity || frag_len_cfg == 0) begin
      r.status = STAT_BAD_INDEX;
    end else begin
      frag = rq.index / frag_len_cfg;
      offset = rq.index % frag_len_cfg;
      pos = frag * MAX_LEN + offset;
      case (rq.req)
        REQ_SET: begin
          if (!frag_active[frag]) begin
            frag_active[frag] = 1'b1;
            active_total++;
            r.spawned = 1'b1;
          end
          if (!used_mem[pos]) begin
            used_mem[pos] = 1'b1;
            frag_fill[frag]++;
            used_total++;
          end
          key_mem[pos] = rq.key;
        end
        REQ_GET: begin
          if (used_mem[pos]) r.read_value = key_mem[pos];
          else r.read_empty = 1'b1;
        end
        default: begin
          if (!used_mem[pos]) begin
            r.status = STAT_DEL_EMPTY;
          end else begin
            used_mem[pos] = 1'b0;
            key_mem[pos] = '0;
            if (frag_fill[frag] > 0) frag_fill[frag]--;
            if (used_total > 0) used_total--;
            if (frag_fill[frag] == 0 && frag_active[frag]) begin
              frag_active[frag] = 1'b0;
              if (active_total > 0) active_total--;
              r.freed = 1'b1;
            end
          end
        end
      endcase
    end
    r.used = USED_W'(used_total);
    r.active = ACTIVE_W'(active_total);
    r.alloc = ALLOC_W'(frag_len_cfg * active_total);
    return r;
  endfunction

  // Request sender: bursts of random length separated by random gaps.
  request_t on_bus;
  int       burst_left = 1;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected.push_back(apply_request(on_bus));
        requests_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          on_bus = pending.pop_front();
          s_axis_tdata <= S_DATA_W'({on_bus.key, on_bus.index});
          s_axis_tuser <= on_bus.req;
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: checks each transaction and stalls on its own pattern.
  rx_mode_t rx_mode = RX_STEADY;
  int       rx_tick = 0;
  int       hold_left = 0;
  int       holdoffs_done = 0;
  result_t  got;
  result_t  want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = status_t'(m_axis_tuser[1:0]);
        got.read_empty = m_axis_tuser[2];
        got.spawned    = m_axis_tuser[3];
        got.freed      = m_axis_tuser[4];
        got.read_value = m_axis_tdata[KEY_W-1:0];
        got.used       = m_axis_tdata[KEY_W +: USED_W];
        got.active     = m_axis_tdata[KEY_W+USED_W +: ACTIVE_W];
        got.alloc      = m_axis_tdata[KEY_W+USED_W+ACTIVE_W +: ALLOC_W];
        if (expected.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result arrived with nothing expected (status %0d)",
                     $realtime, got.status);
        end else begin
          want = expected.pop_front();
          if (got.status !== want.status || got.read_value !== want.read_value ||
              got.read_empty !== want.read_empty || got.spawned !== want.spawned ||
              got.freed !== want.freed || got.used !== want.used ||
              got.active !== want.active || got.alloc !== want.alloc) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%0t: expected st=%0d val=%h emp=%b spw=%b fre=%b used=%0d act=%0d alloc=%0d",
                       $realtime, want.status, want.read_value, want.read_empty,
                       want.spawned, want.freed, want.used, want.active, want.alloc);
              $display("%0t:      got st=%0d val=%h emp=%b spw=%b fre=%b used=%0d act=%0d alloc=%0d",
                       $realtime, got.status, got.read_value, got.read_empty,
                       got.spawned, got.freed, got.used, got.active, got.alloc);
            end
          end
        end
      end
      rx_tick++;
      if (rx_tick % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (holdoffs_done != holdoff_requests) begin
        // Long hold-off so the block backs up into its input.
        holdoffs_done++;
        hold_left = HOLDOFF_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STEADY:   m_axis_tready <= 1'b1;
          RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 99) < 70);
          RX_PERIODIC: m_axis_tready <= (rx_tick % 7 == 0);
          default:     m_axis_tready <= ($urandom_range(0, 99) < 25);
        endcase
      end
    end
  end

  task automatic queue_request(req_t req, logic [IDX_W-1:0] index, logic [KEY_W-1:0] key);
    request_t rq;
    rq.req = req;
    rq.index = index;
    rq.key = key;
    pending.push_back(rq);
    requests_queued++;
  endtask

  // Random request biased toward a few hot cells per fragment, so that
  // fragments are spawned and freed often.
  task automatic queue_random_request();
    int    pick;
    int    capacity;
    int    frag;
    int    hot_span;
    req_t  req;
    logic [IDX_W-1:0] index;
    capacity = frag_count_cfg * frag_len_cfg;
    pick = $urandom_range(0, 99);
    if (pick < 3) req = REQ_CLEAR;
    else if (pick < 43) req = REQ_SET;
    else if (pick < 70) req = REQ_GET;
    else req = REQ_DEL;
    pick = $urandom_range(0, 99);
    if (capacity == 0 || pick < 8) begin
      index = IDX_W'($urandom_range(0, 65535));
    end else if (pick < 12) begin
      index = IDX_W'(capacity + int'($urandom_range(0, 3)));
    end else if (pick < 50) begin
      index = IDX_W'($urandom_range(0, capacity - 1));
    end else begin
      frag = $urandom_range(0, frag_count_cfg - 1);
      hot_span = (frag_len_cfg < 4) ? frag_len_cfg : 4;
      index = IDX_W'(frag * frag_len_cfg + int'($urandom_range(0, hot_span - 1)));
    end
    queue_request(req, index, $urandom());
  endtask

  task automatic wait_drained();
    while (requests_sent != requests_queued || expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    apply_register_write(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Register settings per phase; the last three are drawn at random.
  logic [CFG_DATA_W-1:0] count_setting [NUM_PHASES] =
    '{7'h60, 7'd1, 7'h7F, 7'd16, 7'd5, 7'd16, 7'd1, 7'd3, 7'd0, 7'd0, 7'd0};
  logic [CFG_DATA_W-1:0] length_setting [NUM_PHASES] =
    '{7'd64, 7'd1, 7'h7F, 7'd0, 7'd7, 7'd1, 7'd64, 7'd13, 7'd0, 7'd0, 7'd0};
  int phase_items [NUM_PHASES] =
    '{30, 60, 200, 30, 150, 100, 100, 100, 100, 100, 100};

  // Stimulus sequencing.
  initial begin
    frag_count_cfg = MAX_FRAGS;
    frag_len_cfg = MAX_LEN;
    empty_array();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset layout of 16 fragments of 64 cells.
    queue_request(REQ_GET,   16'd0,     32'h0000_0000);
    queue_request(REQ_SET,   16'd0,     32'h7FFF_FFFF);
    queue_request(REQ_SET,   16'd0,     32'h8000_0000);
    queue_request(REQ_GET,   16'd0,     32'hFFFF_FFFF);
    queue_request(REQ_SET,   16'd1023,  32'hFFFF_FFFF);
    queue_request(REQ_GET,   16'd1023,  32'h0000_0000);
    queue_request(REQ_SET,   16'd1024,  32'h1234_5678);
    queue_request(REQ_GET,   16'hFFFF,  32'h0000_0000);
    queue_request(REQ_DEL,   16'hFFFF,  32'h0000_0000);
    queue_request(REQ_DEL,   16'd5,     32'h0000_0000);
    queue_request(REQ_SET,   16'd63,    32'h0000_0000);
    queue_request(REQ_DEL,   16'd0,     32'h0000_0000);
    queue_request(REQ_GET,   16'd63,    32'h0000_0000);
    queue_request(REQ_DEL,   16'd63,    32'h0000_0000);
    queue_request(REQ_DEL,   16'd1023,  32'h0000_0000);
    queue_request(REQ_GET,   16'd1023,  32'h0000_0000);
    queue_request(REQ_SET,   16'hAAAA,  32'h5555_5555);
    queue_request(REQ_SET,   16'd512,   32'hA5A5_5A5A);
    queue_request(REQ_SET,   16'd575,   32'h0000_0001);
    queue_request(REQ_CLEAR, 16'hFFFF,  32'hFFFF_FFFF);
    queue_request(REQ_GET,   16'd512,   32'h0000_0000);
    queue_request(REQ_DEL,   16'd575,   32'h0000_0000);
    queue_request(REQ_CLEAR, 16'd0,     32'h0000_0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // The sequence waits here until every result of the last phase is in.
      wait_drained();
      if (p >= 8) begin
        count_setting[p] = CFG_DATA_W'($urandom_range(1, 16));
        length_setting[p] = CFG_DATA_W'($urandom_range(1, 64));
      end
      write_register(CFG_FRAG_COUNT, count_setting[p]);
      write_register(CFG_FRAG_LENGTH, length_setting[p]);
      for (int i = 0; i < phase_items[p]; i++) queue_random_request();
      if (p == 2) holdoff_requests++;
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (err_count == 0 && expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
